FILE: rtl/ifla_pkg.sv
// Shared types, codes and defaults for the indexed free-list allocator.
package ifla_pkg;

    localparam int DEF_POOL_ENTRIES    = 64;
    localparam int DEF_MAX_ENTRY_BYTES = 256;

    localparam int ACTION_W = 2;
    localparam int INDEX_W  = 6;
    localparam int TAG_W    = 32;
    localparam int SIZE_W   = 12;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;

    typedef enum logic [ACTION_W-1:0] {
        ACT_ALLOC = 2'd0,
        ACT_FREE  = 2'd1,
        ACT_INIT  = 2'd2,
        ACT_NONE  = 2'd3
    } t_action;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 2'd0,
        ST_EMPTY      = 2'd1,
        ST_TOO_LARGE  = 2'd2,
        ST_NOT_IN_USE = 2'd3
    } t_status;

    // Source of the link store read address.
    typedef enum logic [1:0] {
        RD_LINK      = 2'd0,
        RD_FREE_HEAD = 2'd1,
        RD_USED_HEAD = 2'd2
    } t_rd_sel;

    typedef struct packed {
        logic    capture;
        t_rd_sel rd_sel;
        logic    alloc_commit;
        logic    walk_step;
        logic    unlink;
        logic    relink;
        logic    fill_step;
        logic    fill_done;
        logic    reply;
        t_status reply_status;
        logic    reply_grant;
    } t_dp_cmd;

    typedef struct packed {
        logic size_over;
        logic pool_empty;
        logic target_bad;
        logic walk_end;
        logic walk_hit;
        logic fill_last;
    } t_dp_stat;

endpackage

FILE: rtl/ifla_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ifla_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: rtl/ifla_ctrl.sv
// Sequencing state machine of the allocator: decodes requests, drives datapath commands.
module ifla_ctrl (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    input  logic [ifla_pkg::ACTION_W-1:0]     i_action,
    input  ifla_pkg::t_dp_stat                i_stat,
    output ifla_pkg::t_dp_cmd                 o_cmd,
    output logic                              busy
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_ALLOC  = 5'b00010,
        S_WALK   = 5'b00100,
        S_RELINK = 5'b01000,
        S_INIT   = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_init_reply;
    logic   n_init_reply;
    ifla_pkg::t_dp_cmd cmd;

    always_comb begin
        n_state      = r_state;
        n_init_reply = r_init_reply;
        cmd          = '0;
        cmd.rd_sel   = ifla_pkg::RD_LINK;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    case (ifla_pkg::t_action'(i_action))
                        ifla_pkg::ACT_ALLOC: begin
                            if (i_stat.size_over) begin
                                cmd.reply        = 1'b1;
                                cmd.reply_status = ifla_pkg::ST_TOO_LARGE;
                            end else if (i_stat.pool_empty) begin
                                cmd.reply        = 1'b1;
                                cmd.reply_status = ifla_pkg::ST_EMPTY;
                            end else begin
                                cmd.capture = 1'b1;
                                cmd.rd_sel  = ifla_pkg::RD_FREE_HEAD;
                                n_state     = S_ALLOC;
                            end
                        end
                        ifla_pkg::ACT_FREE: begin
                            if (i_stat.target_bad) begin
                                cmd.reply        = 1'b1;
                                cmd.reply_status = ifla_pkg::ST_NOT_IN_USE;
                            end else begin
                                cmd.capture = 1'b1;
                                cmd.rd_sel  = ifla_pkg::RD_USED_HEAD;
                                n_state     = S_WALK;
                            end
                        end
                        ifla_pkg::ACT_INIT: begin
                            n_init_reply = 1'b1;
                            n_state      = S_INIT;
                        end
                        default: begin
                            cmd.reply        = 1'b1;
                            cmd.reply_status = ifla_pkg::ST_OK;
                        end
                    endcase
                end
            end
            S_ALLOC: begin
                cmd.alloc_commit = 1'b1;
                cmd.reply        = 1'b1;
                cmd.reply_status = ifla_pkg::ST_OK;
                cmd.reply_grant  = 1'b1;
                n_state          = S_IDLE;
            end
            S_WALK: begin
                if (i_stat.walk_hit) begin
                    cmd.unlink = 1'b1;
                    n_state    = S_RELINK;
                end else if (i_stat.walk_end) begin
                    cmd.reply        = 1'b1;
                    cmd.reply_status = ifla_pkg::ST_NOT_IN_USE;
                    n_state          = S_IDLE;
                end else begin
                    cmd.walk_step = 1'b1;
                end
            end
            S_RELINK: begin
                cmd.relink       = 1'b1;
                cmd.reply        = 1'b1;
                cmd.reply_status = ifla_pkg::ST_OK;
                n_state          = S_IDLE;
            end
            S_INIT: begin
                cmd.fill_step = 1'b1;
                if (i_stat.fill_last) begin
                    cmd.fill_done    = 1'b1;
                    cmd.reply        = r_init_reply;
                    cmd.reply_status = ifla_pkg::ST_OK;
                    n_init_reply     = 1'b0;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_INIT;
            r_init_reply <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_init_reply <= n_init_reply;
        end
    end

    assign o_cmd = cmd;
    assign busy  = (r_state != S_IDLE);

endmodule

FILE: rtl/ifla_dp.sv
// Allocator datapath: list heads, count, walk registers, link and entry stores, result word.
module ifla_dp #(
    parameter int POOL_ENTRIES    = ifla_pkg::DEF_POOL_ENTRIES,
    parameter int MAX_ENTRY_BYTES = ifla_pkg::DEF_MAX_ENTRY_BYTES
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic [ifla_pkg::INDEX_W-1:0]      i_entry_index,
    input  logic [ifla_pkg::TAG_W-1:0]        i_owner_tag,
    input  logic [ifla_pkg::SIZE_W-1:0]       i_data_size,
    input  ifla_pkg::t_dp_cmd                 i_cmd,
    output ifla_pkg::t_dp_stat                o_stat,
    output logic                              o_done,
    output logic [ifla_pkg::STATUS_W-1:0]     o_status,
    output logic [ifla_pkg::INDEX_W-1:0]      o_granted_index,
    output logic [ifla_pkg::COUNT_W-1:0]      o_in_use_count
);

    localparam int LW = $clog2(POOL_ENTRIES + 1);
    localparam int AW = $clog2(POOL_ENTRIES);
    localparam int EW = ifla_pkg::TAG_W + ifla_pkg::SIZE_W;
    localparam logic [LW-1:0] NULL_LINK = LW'(POOL_ENTRIES);
    localparam logic [AW-1:0] LAST_ADDR = AW'(POOL_ENTRIES - 1);

    // Clamp a link above the null value to null.
    function automatic logic [LW-1:0] sane(input logic [LW-1:0] link);
        return (link > NULL_LINK) ? NULL_LINK : link;
    endfunction

    // Map a link onto a RAM address; null maps to entry zero.
    function automatic logic [AW-1:0] to_addr(input logic [LW-1:0] link);
        return (link >= NULL_LINK) ? '0 : link[AW-1:0];
    endfunction

    logic [LW-1:0] r_free_head, n_free_head;
    logic [LW-1:0] r_used_head, n_used_head;
    logic [LW-1:0] r_count,     n_count;
    logic [LW-1:0] r_cur,       n_cur;
    logic [LW-1:0] r_prev,      n_prev;
    logic [LW-1:0] r_steps,     n_steps;
    logic [AW-1:0] r_fill,      n_fill;
    logic [LW-1:0] r_target;
    logic [ifla_pkg::TAG_W-1:0]  r_tag;
    logic [ifla_pkg::SIZE_W-1:0] r_size;

    logic                            r_done;
    ifla_pkg::t_status               r_status;
    logic [ifla_pkg::INDEX_W-1:0]    r_granted;
    logic [ifla_pkg::COUNT_W-1:0]    r_count_out;

    logic [LW-1:0] link_rd;
    logic [LW-1:0] link_next;
    logic [LW-1:0] free_sane;
    logic [LW-1:0] used_sane;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [LW-1:0] wr_data;

    assign link_next = sane(link_rd);
    assign free_sane = sane(r_free_head);
    assign used_sane = sane(r_used_head);

    always_comb begin
        case (i_cmd.rd_sel)
            ifla_pkg::RD_FREE_HEAD: rd_addr = to_addr(free_sane);
            ifla_pkg::RD_USED_HEAD: rd_addr = to_addr(used_sane);
            default:                rd_addr = to_addr(link_next);
        endcase
    end

    // One write port serves every link update; no two fall in one cycle.
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = '0;
        if (i_cmd.alloc_commit) begin
            wr_en   = 1'b1;
            wr_addr = to_addr(free_sane);
            wr_data = r_used_head;
        end else if (i_cmd.unlink && (r_prev != NULL_LINK)) begin
            wr_en   = 1'b1;
            wr_addr = to_addr(r_prev);
            wr_data = link_next;
        end else if (i_cmd.relink) begin
            wr_en   = 1'b1;
            wr_addr = to_addr(r_cur);
            wr_data = free_sane;
        end else if (i_cmd.fill_step) begin
            wr_en   = 1'b1;
            wr_addr = r_fill;
            wr_data = LW'(r_fill) + LW'(1);
        end
    end

    always_comb begin
        n_free_head = r_free_head;
        n_used_head = r_used_head;
        n_count     = r_count;
        n_cur       = r_cur;
        n_prev      = r_prev;
        n_steps     = r_steps;
        n_fill      = r_fill;
        if (i_cmd.capture) begin
            n_cur   = used_sane;
            n_prev  = NULL_LINK;
            n_steps = '0;
        end
        if (i_cmd.walk_step) begin
            n_prev  = r_cur;
            n_cur   = link_next;
            n_steps = r_steps + LW'(1);
        end
        if (i_cmd.alloc_commit) begin
            n_free_head = link_next;
            n_used_head = free_sane;
            n_count     = r_count + LW'(1);
        end
        if (i_cmd.unlink && (r_prev == NULL_LINK)) begin
            n_used_head = link_next;
        end
        if (i_cmd.relink) begin
            n_free_head = r_cur;
            if (r_count != '0) begin
                n_count = r_count - LW'(1);
            end
        end
        if (i_cmd.fill_step) begin
            n_fill = (r_fill == LAST_ADDR) ? '0 : r_fill + AW'(1);
        end
        if (i_cmd.fill_done) begin
            n_free_head = '0;
            n_used_head = NULL_LINK;
            n_count     = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free_head <= '0;
            r_used_head <= NULL_LINK;
            r_count     <= '0;
            r_cur       <= NULL_LINK;
            r_prev      <= NULL_LINK;
            r_steps     <= '0;
            r_fill      <= '0;
            r_done      <= 1'b0;
        end else begin
            r_free_head <= n_free_head;
            r_used_head <= n_used_head;
            r_count     <= n_count;
            r_cur       <= n_cur;
            r_prev      <= n_prev;
            r_steps     <= n_steps;
            r_fill      <= n_fill;
            r_done      <= i_cmd.reply;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_target <= LW'({{(32 - ifla_pkg::INDEX_W){1'b0}}, i_entry_index});
            r_tag    <= i_owner_tag;
            r_size   <= i_data_size;
        end
        if (i_cmd.reply) begin
            r_status    <= i_cmd.reply_status;
            r_granted   <= i_cmd.reply_grant ? ifla_pkg::INDEX_W'(free_sane) : '0;
            r_count_out <= ifla_pkg::COUNT_W'(n_count);
        end
    end

    ifla_ram #(
        .WIDTH (LW),
        .DEPTH (POOL_ENTRIES)
    ) u_link_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (link_rd)
    );

    // Tag and size per entry; kept for the owner, never fed back into the lists.
    ifla_ram #(
        .WIDTH (EW),
        .DEPTH (POOL_ENTRIES)
    ) u_entry_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.alloc_commit),
        .i_wr_addr (to_addr(free_sane)),
        .i_wr_data ({r_tag, r_size}),
        .i_rd_addr ('0),
        .o_rd_data ()
    );

    assign o_stat.size_over  = (i_data_size > ifla_pkg::SIZE_W'(MAX_ENTRY_BYTES));
    assign o_stat.pool_empty = (free_sane == NULL_LINK);
    assign o_stat.target_bad = ({{(32 - ifla_pkg::INDEX_W){1'b0}}, i_entry_index}
                                >= 32'(POOL_ENTRIES));
    assign o_stat.walk_end   = (r_steps >= NULL_LINK) || (r_cur >= NULL_LINK);
    assign o_stat.walk_hit   = (r_cur == r_target);
    assign o_stat.fill_last  = (r_fill == LAST_ADDR);

    assign o_done          = r_done;
    assign o_status        = r_status;
    assign o_granted_index = r_granted;
    assign o_in_use_count  = r_count_out;

endmodule

FILE: rtl/indexed_free_list_allocator_core.sv
// Reject or no-op replies from idle, allocate passes through S_ALLOC, free walks the
// in-use list (S_RELINK on a hit), initialize runs the fill pass; one item at a time.
// Free time is set by the in-use list walk: one link store read per cycle.
// Initialize and reset rebuild the link store with one RAM write per entry;
// busy stays high during that pass after reset.
// Reset is synchronous, active low; o_done pulses one cycle, the receiver cannot stall.
module indexed_free_list_allocator_core #(
    parameter int POOL_ENTRIES    = ifla_pkg::DEF_POOL_ENTRIES,
    parameter int MAX_ENTRY_BYTES = ifla_pkg::DEF_MAX_ENTRY_BYTES
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [ifla_pkg::ACTION_W-1:0]     i_action,
    input  logic [ifla_pkg::INDEX_W-1:0]      i_entry_index,
    input  logic [ifla_pkg::TAG_W-1:0]        i_owner_tag,
    input  logic [ifla_pkg::SIZE_W-1:0]       i_data_size,
    output logic                              o_done,
    output logic [ifla_pkg::STATUS_W-1:0]     o_status,
    output logic [ifla_pkg::INDEX_W-1:0]      o_granted_index,
    output logic [ifla_pkg::COUNT_W-1:0]      o_in_use_count
);

    // Command word from the controller, status word back from the datapath.
    ifla_pkg::t_dp_cmd  dp_cmd;
    ifla_pkg::t_dp_stat dp_stat;

    // Controller: decode the word on accept, step the walk, drive the fill pass.
    ifla_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_action (i_action),
        .i_stat   (dp_stat),
        .o_cmd    (dp_cmd),
        .busy     (busy)
    );

    // Datapath: hold both list heads, the count, and the shared next-link store.
    ifla_dp #(
        .POOL_ENTRIES    (POOL_ENTRIES),
        .MAX_ENTRY_BYTES (MAX_ENTRY_BYTES)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_entry_index   (i_entry_index),
        .i_owner_tag     (i_owner_tag),
        .i_data_size     (i_data_size),
        .i_cmd           (dp_cmd),
        .o_stat          (dp_stat),
        .o_done          (o_done),
        .o_status        (o_status),
        .o_granted_index (o_granted_index),
        .o_in_use_count  (o_in_use_count)
    );

`ifndef ASSERT_OFF
    // A result word only appears once the controller has gone back to idle.
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result word while busy");

    // Only a successful allocate hands out an index.
    a_grant_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status != ifla_pkg::ST_OK)) |-> (o_granted_index == '0))
        else $error("granted index on a failed request");

    // An unused action code answers in the next cycle.
    a_noop_reply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_action == ifla_pkg::ACT_NONE)) |=> o_done)
        else $error("no reply to unused action code");

    // The walk never unlinks and steps in the same cycle.
    a_walk_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(dp_cmd.unlink && dp_cmd.walk_step))
        else $error("walk step and unlink together");
`endif

endmodule
